[hdl/sfmf_pkg.sv]
// shared types and constants of the substring first match finder
package sfmf_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 8;

    localparam logic [COUNT_W-1:0] SOURCE_LIMIT = 8'd255;

    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SOURCE  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_FINISH  = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_PATTERN,
        OP_SOURCE,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] match_start;
        logic               too_long;
        logic               overflow;
    } t_result;

endpackage

[hdl/sfmf_front.sv]
// front stage: takes input transactions and decodes them into commands
module sfmf_front
    import sfmf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [BYTE_W-1:0]   i_data_byte,
    output logic                o_full,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  logic                i_cmd_ready
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_full      = r_valid && !i_cmd_ready;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd      = r_cmd;
        n_valid    = r_valid && !i_cmd_ready;
        if (accept) begin
            n_valid    = 1'b1;
            n_cmd.data = i_data_byte;
            unique case (i_action)
                ACT_CLEAR:   n_cmd.op = OP_CLEAR;
                ACT_PATTERN: n_cmd.op = OP_PATTERN;
                ACT_SOURCE:  n_cmd.op = OP_SOURCE;
                ACT_FINISH:  n_cmd.op = OP_FINISH;
                default:     n_cmd.op = OP_FINISH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    a_full_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> r_valid)
        else $error("front reports full with no command held");

    a_stall_keeps_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_cmd_ready) |=> (r_valid && r_cmd == $past(r_cmd)))
        else $error("stalled command changed in front stage");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_valid && r_cmd.data == $past(i_data_byte)))
        else $error("accepted transaction not captured");

endmodule

[hdl/sfmf_queue.sv]
// short command queue between the front and back stages
module sfmf_queue
    import sfmf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    input  t_cmd i_wr_cmd,
    output logic o_wr_ready,
    output logic o_rd_valid,
    output t_cmd o_rd_cmd,
    input  logic i_rd_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_wr;
    logic             do_rd;

    assign o_wr_ready = (r_count != FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign do_wr      = i_wr_valid && o_wr_ready;
    assign do_rd      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_ptrs_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_CNT) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && r_count == '0) |=> (o_rd_valid && o_rd_cmd == $past(i_wr_cmd)))
        else $error("write into empty queue not visible at head");

endmodule

[hdl/sfmf_back.sv]
// back stage: pattern store, source window, parallel compare and result register
module sfmf_back
    import sfmf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_ready,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);

    // r_pat[0] holds the last pattern byte, so r_pat[j] lines up with window slot j
    logic [BYTE_W-1:0]  r_pat [PATTERN_MAX];
    logic [BYTE_W-1:0]  r_win [PATTERN_MAX];
    logic [BYTE_W-1:0]  new_win [PATTERN_MAX];
    logic [LEN_W-1:0]   r_pat_len;
    logic [COUNT_W-1:0] r_src_count;
    logic [COUNT_W-1:0] r_first_match;
    logic               r_too_long;
    logic               r_overflow;
    logic               r_out_valid;
    t_result            r_out;

    logic               exec;
    logic               do_pattern;
    logic               do_source;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] len_ext;
    logic [PATTERN_MAX-1:0] hit;
    logic               window_match;
    t_result            fin_res;

    assign o_cmd_ready = !(i_cmd.op == OP_FINISH) || !r_out_valid || i_res_ready;
    assign exec        = i_cmd_valid && o_cmd_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign do_pattern = exec && i_cmd.op == OP_PATTERN && r_src_count == '0
                        && r_pat_len != LEN_FULL;
    assign do_source  = exec && i_cmd.op == OP_SOURCE && r_src_count != SOURCE_LIMIT;
    assign count_inc  = r_src_count + 1'b1;
    assign len_ext    = COUNT_W'(r_pat_len);

    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (j == 0) begin
                new_win[j] = i_cmd.data;
            end else begin
                new_win[j] = r_win[j-1];
            end
            hit[j] = (LEN_W'(j) >= r_pat_len) || (new_win[j] == r_pat[j]);
        end
        window_match = &hit;
    end

    always_comb begin
        fin_res.too_long = r_too_long;
        fin_res.overflow = r_overflow;
        priority if (r_too_long) begin
            fin_res.match_start = '0;
        end else if (r_pat_len == '0) begin
            fin_res.match_start = COUNT_W'(r_src_count != '0);
        end else begin
            fin_res.match_start = r_first_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len     <= '0;
            r_src_count   <= '0;
            r_first_match <= '0;
            r_too_long    <= 1'b0;
            r_overflow    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (exec) begin
                unique case (i_cmd.op)
                    OP_CLEAR: begin
                        r_pat_len     <= '0;
                        r_src_count   <= '0;
                        r_first_match <= '0;
                        r_too_long    <= 1'b0;
                        r_overflow    <= 1'b0;
                    end
                    OP_PATTERN: begin
                        if (r_src_count == '0) begin
                            if (r_pat_len != LEN_FULL) begin
                                r_pat_len <= r_pat_len + 1'b1;
                            end else begin
                                r_too_long <= 1'b1;
                            end
                        end
                    end
                    OP_SOURCE: begin
                        if (r_src_count == SOURCE_LIMIT) begin
                            r_overflow <= 1'b1;
                        end else begin
                            r_src_count <= count_inc;
                            if (r_first_match == '0 && !r_too_long && r_pat_len != '0
                                && count_inc >= len_ext && window_match) begin
                                r_first_match <= count_inc - len_ext + 1'b1;
                            end
                        end
                    end
                    OP_FINISH: begin
                        r_out_valid <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (exec && i_cmd.op == OP_FINISH) begin
            r_out <= fin_res;
        end
        if (do_pattern) begin
            r_pat[0] <= i_cmd.data;
            for (int j = 1; j < PATTERN_MAX; j++) begin
                r_pat[j] <= r_pat[j-1];
            end
        end
        if (do_source) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= new_win[j];
            end
        end
    end

    a_match_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first_match != '0) |-> (r_src_count >= len_ext && r_pat_len != '0))
        else $error("first match recorded before enough source bytes");

    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && i_cmd.op == OP_FINISH) |=> r_out_valid)
        else $error("finish command produced no result");

    a_too_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.too_long) |-> (r_out.match_start == '0))
        else $error("match reported with overlong pattern");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat_len <= LEN_FULL)
        else $error("pattern length beyond capacity");

endmodule

[hdl/substring_first_match_finder.sv]
// top level: front decode stage, command queue and search back end
// a finish goes through the front register and the queue into the result register
// throughput: one transaction per cycle unless full, set by the combinational compare
// a finish waits in the back end only while an unread result occupies the output register
// reset is synchronous active low: clears lengths, counts, flags, queue and result valid
// pattern and window bytes are not cleared; they are only read below the tracked lengths
module substring_first_match_finder
    import sfmf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [BYTE_W-1:0]   i_data_byte,
    output logic                empty,
    input  logic                pop,
    output logic [COUNT_W-1:0]  o_match_start,
    output logic                o_pattern_too_long,
    output logic                o_source_overflow
);

    logic    front_valid;
    t_cmd    front_cmd;
    logic    q_wr_ready;
    logic    q_rd_valid;
    t_cmd    q_rd_cmd;
    logic    back_ready;
    logic    res_valid;
    t_result res;

    sfmf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_full      (full),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (q_wr_ready)
    );

    sfmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .i_wr_cmd   (front_cmd),
        .o_wr_ready (q_wr_ready),
        .o_rd_valid (q_rd_valid),
        .o_rd_cmd   (q_rd_cmd),
        .i_rd_ready (back_ready)
    );

    sfmf_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_rd_valid),
        .i_cmd       (q_rd_cmd),
        .o_cmd_ready (back_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (pop)
    );

    assign empty              = !res_valid;
    assign o_match_start      = res.match_start;
    assign o_pattern_too_long = res.too_long;
    assign o_source_overflow  = res.overflow;

endmodule

[tb/sv/substring_first_match_finder_tb.sv]
// self-checking testbench of the substring first match finder
`timescale 1ns / 1ps

module substring_first_match_finder_tb;
    import sfmf_pkg::*;

    localparam int PATTERN_SLOTS  = PATTERN_MAX_DEF;
    localparam int ITEM_TARGET    = 1600;
    localparam int PHASE_ITEMS    = 540;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [BYTE_W-1:0]   data;
        logic                typed;
        logic [COUNT_W-1:0]  match_start;
        logic                too_long;
        logic                overflow;
    } t_step_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [ACTION_W-1:0] i_action = ACT_CLEAR;
    logic [BYTE_W-1:0]   i_data_byte = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [COUNT_W-1:0]  o_match_start;
    logic                o_pattern_too_long;
    logic                o_source_overflow;

    // predictor state
    logic [BYTE_W-1:0] pat_bytes [PATTERN_SLOTS];
    logic [BYTE_W-1:0] recent_src [PATTERN_SLOTS];
    int                pat_len = 0;
    int                src_count = 0;
    int                first_hit = 0;
    bit                too_long = 1'b0;
    bit                overflow = 1'b0;

    t_result pending_reports [$];
    int      items_sent = 0;
    int      idle_phase = 0;
    int      error_count = 0;
    int      quiet_cycles = 0;

    // finish rows with a typed result: after reset, empty pattern, after clear
    t_step_row step_table [DIRECTED_ROWS] = '{
        '{ACT_FINISH,  8'h00, 1'b1, 8'd0, 1'b0, 1'b0},
        '{ACT_SOURCE,  8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_FINISH,  8'hFF, 1'b1, 8'd1, 1'b0, 1'b0},
        '{ACT_CLEAR,   8'hFF, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_PATTERN, 8'hFF, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_PATTERN, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_SOURCE,  8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_SOURCE,  8'hFF, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_SOURCE,  8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_FINISH,  8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_PATTERN, 8'h55, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_SOURCE,  8'hFF, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_FINISH,  8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_CLEAR,   8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_FINISH,  8'h00, 1'b1, 8'd0, 1'b0, 1'b0},
        '{ACT_PATTERN, 8'hAA, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_SOURCE,  8'h55, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_FINISH,  8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_SOURCE,  8'hAA, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_FINISH,  8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_CLEAR,   8'h00, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_PATTERN, 8'h5A, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_SOURCE,  8'h5A, 1'b0, 8'd0, 1'b0, 1'b0},
        '{ACT_FINISH,  8'hA5, 1'b0, 8'd0, 1'b0, 1'b0}
    };

    substring_first_match_finder dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_action           (i_action),
        .i_data_byte        (i_data_byte),
        .empty              (empty),
        .pop                (pop),
        .o_match_start      (o_match_start),
        .o_pattern_too_long (o_pattern_too_long),
        .o_source_overflow  (o_source_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // advances the search state by one transaction, returns 1 when a report is due
    function automatic bit search_step(input logic [ACTION_W-1:0] act,
                                       input logic [BYTE_W-1:0] b, output t_result res);
        int k;
        bit hit;
        bit got;
        got = 1'b0;
        res = '0;
        case (act)
            ACT_CLEAR: begin
                pat_len = 0;
                src_count = 0;
                first_hit = 0;
                too_long = 1'b0;
                overflow = 1'b0;
                for (k = 0; k < PATTERN_SLOTS; k++) recent_src[k] = '0;
            end
            ACT_PATTERN: begin
                if (src_count == 0) begin
                    if (pat_len < PATTERN_SLOTS) begin
                        pat_bytes[pat_len] = b;
                        pat_len++;
                    end else begin
                        too_long = 1'b1;
                    end
                end
            end
            ACT_SOURCE: begin
                if (src_count >= int'(SOURCE_LIMIT)) begin
                    overflow = 1'b1;
                end else begin
                    for (k = PATTERN_SLOTS - 1; k > 0; k--) recent_src[k] = recent_src[k-1];
                    recent_src[0] = b;
                    src_count++;
                    if (first_hit == 0 && !too_long && pat_len > 0 && src_count >= pat_len) begin
                        hit = 1'b1;
                        // newest byte sits at index 0, so the pattern runs backwards
                        for (k = 0; k < pat_len; k++)
                            if (pat_bytes[k] != recent_src[pat_len-1-k]) hit = 1'b0;
                        if (hit) first_hit = src_count - pat_len + 1;
                    end
                end
            end
            ACT_FINISH: begin
                if (too_long) res.match_start = '0;
                else if (pat_len == 0) res.match_start = (src_count > 0) ? 8'd1 : 8'd0;
                else res.match_start = COUNT_W'(first_hit);
                res.too_long = too_long;
                res.overflow = overflow;
                got = 1'b1;
            end
            default: ;
        endcase
        return got;
    endfunction

    function automatic int sender_idle_pct();
        return (idle_phase == 0) ? 23 : (idle_phase == 1) ? 65 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (idle_phase == 0) ? 65 : (idle_phase == 1) ? 23 : 0;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte(input bit wide, input logic [BYTE_W-1:0] base);
        return wide ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(base + $urandom_range(0, 2));
    endfunction

    // drives one transaction from the falling edge and waits until it is taken
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                             input bit typed, input t_result typed_res);
        t_result res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct()) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_action <= act;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (search_step(act, b, res)) pending_reports.push_back(typed ? typed_res : res);
        items_sent++;
        idle_phase = (items_sent < PHASE_ITEMS) ? 0 : (items_sent < 2 * PHASE_ITEMS) ? 1 : 2;
    endtask

    // random items, or maybe clear, pattern, source (often a planted copy); finish
    task automatic run_random_search(input bit force_long, input bit force_overflow);
        logic [BYTE_W-1:0] pat [$];
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] b;
        int plen, slen, plant_at, roll, k;
        bit wide, long_pat, big_src;
        base = BYTE_W'($urandom_range(0, 255));
        wide = ($urandom_range(0, 4) == 0);
        roll = $urandom_range(0, 99);
        long_pat = force_long || (!force_overflow && roll >= 3 && roll < 10);
        big_src = force_overflow || (!force_long && roll < 3);
        if (!force_long && !force_overflow && roll >= 10 && roll < 18) begin
            repeat ($urandom_range(1, 10))
                send_item(ACTION_W'($urandom_range(0, 3)), pick_byte(1'b1, base), 1'b0, '0);
        end else begin
            if ($urandom_range(0, 9) != 0) send_item(ACT_CLEAR, pick_byte(1'b1, base), 1'b0, '0);
            if (long_pat) begin
                plen = $urandom_range(PATTERN_SLOTS + 1, PATTERN_SLOTS + 4);
            end else begin
                roll = $urandom_range(0, 9);
                plen = (roll == 0) ? 0 : (roll == 1) ? PATTERN_SLOTS : $urandom_range(1, 5);
            end
            for (k = 0; k < plen; k++) begin
                b = pick_byte(wide, base);
                pat.push_back(b);
                send_item(ACT_PATTERN, b, 1'b0, '0);
            end
            if (big_src) slen = $urandom_range(int'(SOURCE_LIMIT), int'(SOURCE_LIMIT) + 8);
            else if ($urandom_range(0, 5) == 0) slen = $urandom_range(0, plen);
            else slen = plen + $urandom_range(0, 24);
            plant_at = -1;
            if (plen > 0 && slen >= plen && $urandom_range(0, 9) < 6) begin
                // in a long source, often put the copy at the last start that still counts
                if (big_src && $urandom_range(0, 1) == 1) plant_at = int'(SOURCE_LIMIT) - plen;
                else plant_at = $urandom_range(0, slen - plen);
            end
            for (k = 0; k < slen; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) send_item(ACT_FINISH, pick_byte(1'b1, base), 1'b0, '0);
                else if (roll < 6) send_item(ACT_PATTERN, pick_byte(wide, base), 1'b0, '0);
                if (plant_at >= 0 && k >= plant_at && k < plant_at + plen) b = pat[k-plant_at];
                else b = pick_byte(wide, base);
                send_item(ACT_SOURCE, b, 1'b0, '0);
            end
        end
        send_item(ACT_FINISH, pick_byte(1'b1, base), 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(0, 99) >= receiver_idle_pct());
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_reports.size() == 0) begin
                $display("%0t unexpected result: match_start %0d too_long %0b overflow %0b",
                         $time, o_match_start, o_pattern_too_long, o_source_overflow);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (o_match_start !== want.match_start) begin
                    $display("%0t match_start expected %0d actual %0d",
                             $time, want.match_start, o_match_start);
                    error_count++;
                end
                if (o_pattern_too_long !== want.too_long) begin
                    $display("%0t pattern_too_long expected %0b actual %0b",
                             $time, want.too_long, o_pattern_too_long);
                    error_count++;
                end
                if (o_source_overflow !== want.overflow) begin
                    $display("%0t source_overflow expected %0b actual %0b",
                             $time, want.overflow, o_source_overflow);
                    error_count++;
                end
            end
        end
    end

    // no transaction on either side for too long means the block hung
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAIL substring_first_match_finder");
            $finish;
        end
    end

    initial begin
        t_result typed_res;
        int row;
        int seq_index;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            typed_res.match_start = step_table[row].match_start;
            typed_res.too_long = step_table[row].too_long;
            typed_res.overflow = step_table[row].overflow;
            send_item(step_table[row].act, step_table[row].data, step_table[row].typed, typed_res);
        end

        // first two searches force a too-long pattern and a source overflow
        seq_index = 0;
        while (items_sent < ITEM_TARGET) begin
            run_random_search(seq_index == 0, seq_index == 1);
            seq_index++;
        end

        @(negedge i_clk);
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("PASS substring_first_match_finder");
        end else begin
            $display("FAIL substring_first_match_finder");
        end
        $finish;
    end

endmodule
